// File: design/cdrf_pkg.sv
package cdrf_pkg;

   localparam int NUM_STEPS = 11;

   // result steps of one command, emitted lowest index first
   localparam int STEP_HDR   = 0;
   localparam int STEP_LEN   = 1;
   localparam int STEP_WORD  = 2;
   localparam int STEP_TRL   = 3;
   localparam int STEP_ERR   = 4;
   localparam int STEP_PART  = 5;
   localparam int STEP_PAD   = 6;
   localparam int STEP_CLOSE = 7;
   localparam int STEP_ENDH  = 8;
   localparam int STEP_ENDZ  = 9;
   localparam int STEP_ENDL  = 10;

   localparam logic [15:0] MAX_BYTES     = 16'd32768;
   localparam logic [2:0]  PAYLOAD_WORDS = 3'd7;
   localparam logic [3:0]  END_ZERO_WORDS = 4'd8;

   localparam logic [31:0] TXT_HEAD = 32'h02E3E7E3;
   localparam logic [31:0] END_HEAD = 32'h02C5D5C4;
   localparam logic [63:0] LEN_WORD = 64'h0000003800000000;

   localparam int CMDQ_AW    = 2;
   localparam int CMDQ_DEPTH = 1 << CMDQ_AW;

   typedef struct packed {
      logic [NUM_STEPS-1:0] steps;
      logic [63:0]          word;
      logic [15:0]          offset;
      logic [2:0]           pad_zeros;
   } cmd_type;

   typedef struct packed {
      logic [63:0] card_word;
      logic        card_end;
      logic        deck_end;
      logic        size_error;
   } rsp_type;

endpackage

// File: design/cdrf_front.sv
module cdrf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [7:0]        req_data_byte,
   input  logic              req_byte_valid,
   input  logic              req_end_of_input,
   input  logic              cmd_full,
   output logic              cmd_push,
   output cdrf_pkg::cmd_type cmd
);
   import cdrf_pkg::*;

   logic [15:0] offset_ff, offset_in;
   logic [55:0] buf_ff, buf_in;
   logic [2:0]  bw_ff, bw_in;
   logic [2:0]  wic_ff, wic_in;
   logic        err_ff, err_in;

   logic        accept;
   logic [63:0] full_word;
   logic [63:0] part_word;
   logic [5:0]  shamt;
   logic [2:0]  wic_pad;

   assign req_full  = cmd_full;
   assign accept    = req_push && !cmd_full;
   assign full_word = {buf_ff, req_data_byte};

   always_comb begin
      offset_in = offset_ff;
      buf_in    = buf_ff;
      bw_in     = bw_ff;
      wic_in    = wic_ff;
      err_in    = err_ff;
      cmd       = '0;
      wic_pad   = '0;
      shamt     = '0;
      part_word = '0;
      if (accept) begin
         if (req_byte_valid && !err_ff) begin
            if (offset_ff >= MAX_BYTES) begin
               err_in = 1'b1;
               cmd.steps[STEP_ERR] = 1'b1;
            end else begin
               if (bw_ff == 3'd0 && wic_ff == 3'd0) begin
                  cmd.steps[STEP_HDR] = 1'b1;
                  cmd.steps[STEP_LEN] = 1'b1;
                  cmd.offset = offset_ff;
               end
               offset_in = offset_ff + 16'd1;
               if (bw_ff == 3'd7) begin
                  cmd.steps[STEP_WORD] = 1'b1;
                  cmd.word = full_word;
                  buf_in = '0;
                  bw_in  = '0;
                  if (wic_ff == PAYLOAD_WORDS - 3'd1) begin
                     cmd.steps[STEP_TRL] = 1'b1;
                     wic_in = '0;
                  end else begin
                     wic_in = wic_ff + 3'd1;
                  end
               end else begin
                  buf_in = full_word[55:0];
                  bw_in  = bw_ff + 3'd1;
               end
            end
         end
         if (req_end_of_input) begin
            if (!err_in) begin
               if (bw_in != 3'd0 || wic_in != 3'd0) begin
                  wic_pad = wic_in;
                  if (bw_in != 3'd0) begin
                     shamt     = {3'(4'd8 - {1'b0, bw_in}), 3'b000};
                     part_word = {8'h00, buf_in} << shamt;
                     cmd.steps[STEP_PART] = 1'b1;
                     cmd.word = part_word;
                     wic_pad  = wic_in + 3'd1;
                  end
                  cmd.pad_zeros = PAYLOAD_WORDS - wic_pad;
                  cmd.steps[STEP_PAD]   = (cmd.pad_zeros != 3'd0);
                  cmd.steps[STEP_CLOSE] = 1'b1;
               end
               cmd.steps[STEP_ENDH] = 1'b1;
               cmd.steps[STEP_ENDZ] = 1'b1;
               cmd.steps[STEP_ENDL] = 1'b1;
            end
            offset_in = '0;
            buf_in    = '0;
            bw_in     = '0;
            wic_in    = '0;
            err_in    = 1'b0;
         end
      end
   end

   assign cmd_push = accept && (cmd.steps != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         buf_ff    <= '0;
         bw_ff     <= '0;
         wic_ff    <= '0;
         err_ff    <= 1'b0;
      end else begin
         offset_ff <= offset_in;
         buf_ff    <= buf_in;
         bw_ff     <= bw_in;
         wic_ff    <= wic_in;
         err_ff    <= err_in;
      end
   end

endmodule

// File: design/cdrf_cmdq.sv
module cdrf_cmdq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cdrf_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output cdrf_pkg::cmd_type pop_cmd,
   output logic              empty
);
   import cdrf_pkg::*;

   cmd_type              q_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_AW:0]     cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign full    = (cnt_ff == (CMDQ_AW+1)'(CMDQ_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: design/cdrf_back.sv
module cdrf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [23:0]       start_addr,
   input  logic              cmd_empty,
   input  cdrf_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [63:0]       rsp_card_word,
   output logic              rsp_card_end,
   output logic              rsp_deck_end,
   output logic              rsp_size_error
);
   import cdrf_pkg::*;

   logic [NUM_STEPS-1:0] en_ff, en_in;
   logic [63:0]          word_ff, word_in;
   logic [15:0]          offset_ff, offset_in;
   logic [2:0]           pad_left_ff, pad_left_in;
   logic [3:0]           endz_left_ff, endz_left_in;

   logic [NUM_STEPS-1:0] cur;
   logic [NUM_STEPS-1:0] en_after;
   logic                 emit;
   logic                 keep;
   rsp_type              res;

   // two-entry result queue
   rsp_type              out_q_ff [2];
   logic                 out_wr_ff, out_rd_ff;
   logic [1:0]           out_cnt_ff, out_cnt_in;
   logic                 out_pop;

   assign cur  = en_ff & (~en_ff + 1'b1);
   assign emit = (en_ff != '0) && (out_cnt_ff != 2'd2);

   always_comb begin
      keep = 1'b0;
      if (cur[STEP_PAD] && pad_left_ff > 3'd1) begin
         keep = 1'b1;
      end
      if (cur[STEP_ENDZ] && endz_left_ff > 4'd1) begin
         keep = 1'b1;
      end
      en_after = en_ff;
      if (emit && !keep) begin
         en_after = en_ff & ~cur;
      end
   end

   assign cmd_pop = (en_after == '0) && !cmd_empty;

   always_comb begin
      en_in        = en_after;
      word_in      = word_ff;
      offset_in    = offset_ff;
      pad_left_in  = pad_left_ff;
      endz_left_in = endz_left_ff;
      if (emit && cur[STEP_PAD]) begin
         pad_left_in = pad_left_ff - 3'd1;
      end
      if (emit && cur[STEP_ENDZ]) begin
         endz_left_in = endz_left_ff - 4'd1;
      end
      if (cmd_pop) begin
         en_in        = cmd.steps;
         word_in      = cmd.word;
         offset_in    = cmd.offset;
         pad_left_in  = cmd.pad_zeros;
         endz_left_in = END_ZERO_WORDS;
      end
   end

   always_comb begin
      res = '0;
      unique case (1'b1)
         cur[STEP_HDR]:   res.card_word = {TXT_HEAD, 16'h0000, offset_ff};
         cur[STEP_LEN]:   res.card_word = LEN_WORD;
         cur[STEP_WORD]:  res.card_word = word_ff;
         cur[STEP_TRL]:   res.card_end = 1'b1;
         cur[STEP_ERR]: begin
            res.deck_end   = 1'b1;
            res.size_error = 1'b1;
         end
         cur[STEP_PART]:  res.card_word = word_ff;
         cur[STEP_PAD]:   res.card_word = '0;
         cur[STEP_CLOSE]: res.card_end = 1'b1;
         cur[STEP_ENDH]:  res.card_word = {END_HEAD, 8'h00, start_addr};
         cur[STEP_ENDZ]:  res.card_word = '0;
         cur[STEP_ENDL]: begin
            res.card_end = 1'b1;
            res.deck_end = 1'b1;
         end
         default:         res = '0;
      endcase
   end

   assign rsp_empty      = (out_cnt_ff == 2'd0);
   assign out_pop        = rsp_pop && !rsp_empty;
   assign rsp_card_word  = out_q_ff[out_rd_ff].card_word;
   assign rsp_card_end   = out_q_ff[out_rd_ff].card_end;
   assign rsp_deck_end   = out_q_ff[out_rd_ff].deck_end;
   assign rsp_size_error = out_q_ff[out_rd_ff].size_error;

   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (emit && !out_pop) begin
         out_cnt_in = out_cnt_ff + 2'd1;
      end else if (out_pop && !emit) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      offset_ff    <= offset_in;
      pad_left_ff  <= pad_left_in;
      endz_left_ff <= endz_left_in;
      if (emit) begin
         out_q_ff[out_wr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff      <= '0;
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
         out_cnt_ff <= '0;
      end else begin
         en_ff      <= en_in;
         out_wr_ff  <= emit ? ~out_wr_ff : out_wr_ff;
         out_rd_ff  <= out_pop ? ~out_rd_ff : out_rd_ff;
         out_cnt_ff <= out_cnt_in;
      end
   end

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      emit |-> $onehot(cur))
      else $error("more than one step selected");

   a_err_result: assert property (@(posedge clock) disable iff (reset)
      (emit && res.size_error) |-> (res.card_word == '0 && res.deck_end && !res.card_end))
      else $error("malformed size error result");

   a_deck_close: assert property (@(posedge clock) disable iff (reset)
      (emit && res.deck_end && !res.size_error) |-> (res.card_end && en_after == '0))
      else $error("deck end not on last word of command");

endmodule

// File: design/card_deck_record_framer.sv
// Frames a byte stream into 80-byte object-deck cards, each delivered as ten
// 64-bit big-endian words (TXT cards with a 24-bit load offset and 56 payload
// bytes, then a closing END card carrying the start address). One item is
// accepted per clock while the four-entry command queue between the byte packer
// and the card sequencer has room; items that produce no result leave nothing in
// the queue. The sequencer delivers one result word per clock while its two-entry
// result queue has room, so sustained input rate is set by result volume: a byte
// item yields 0 to 2 words, an end item up to 20. Card headers, full words and
// padding are buffered as commands, so a stalled result side holds the input
// only once the queue fills. Write the start address only while the block is idle.
module card_deck_record_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_input,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_card_word,
   output logic        rsp_card_end,
   output logic        rsp_deck_end,
   output logic        rsp_size_error,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data
);
   import cdrf_pkg::*;

   logic [23:0] start_addr_ff;
   logic        cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type     push_cmd, pop_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_addr_ff <= '0;
      end else if (csr_wr_en) begin
         start_addr_ff <= csr_wr_data;
      end
   end

   cdrf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_byte_valid   (req_byte_valid),
      .req_end_of_input (req_end_of_input),
      .cmd_full         (cmd_full),
      .cmd_push         (cmd_push),
      .cmd              (push_cmd)
   );

   cdrf_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .pop_cmd  (pop_cmd),
      .empty    (cmd_empty)
   );

   cdrf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .start_addr     (start_addr_ff),
      .cmd_empty      (cmd_empty),
      .cmd            (pop_cmd),
      .cmd_pop        (cmd_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_card_word  (rsp_card_word),
      .rsp_card_end   (rsp_card_end),
      .rsp_deck_end   (rsp_deck_end),
      .rsp_size_error (rsp_size_error)
   );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int          DECK_LIMIT     = 32768;
   localparam int          PAYLOAD_WORDS  = 7;
   localparam int          END_FILL_WORDS = 8;
   localparam logic [31:0] TXT_TAG        = 32'h02E3E7E3;
   localparam logic [31:0] END_TAG        = 32'h02C5D5C4;
   localparam logic [63:0] LEN_FIELD      = 64'h0000003800000000;
   localparam int          RANDOM_ITEMS   = 110;
   localparam int          MAX_GAP        = 13;
   localparam int          HOLD_CYCLES    = 180;
   localparam int          DRAIN_CYCLES   = 32;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          PRINT_LIMIT    = 40;

   typedef struct packed {
      logic [63:0] word;
      logic        card_end;
      logic        deck_end;
      logic        size_error;
   } card_result_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_push         = 1'b0;
   logic        req_full;
   logic [7:0]  req_data_byte    = 8'h00;
   logic        req_byte_valid   = 1'b0;
   logic        req_end_of_input = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop          = 1'b0;
   logic [63:0] rsp_card_word;
   logic        rsp_card_end;
   logic        rsp_deck_end;
   logic        rsp_size_error;
   logic        csr_wr_en        = 1'b0;
   logic [23:0] csr_wr_data      = 24'h000000;

   // framer state as seen by the predictor
   logic [15:0]     deck_offset   = '0;
   logic [55:0]     pending_bytes = '0;
   logic [2:0]      pending_count = '0;
   logic [2:0]      words_in_card = '0;
   logic            overflow_seen = 1'b0;
   logic [23:0]     entry_addr    = '0;
   card_result_type card_queue[$];

   bit tx_quiet     = 1'b0;
   bit rx_quiet     = 1'b0;
   bit no_gaps      = 1'b0;
   int hold_request = 0;

   int mismatches   = 0;
   int items_in     = 0;
   int words_out    = 0;
   int cards_out    = 0;
   int decks_out    = 0;
   int errors_out   = 0;
   int entry_writes = 0;
   int idle_cycles  = 0;

   card_deck_record_framer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_byte_valid   (req_byte_valid),
      .req_end_of_input (req_end_of_input),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_card_word    (rsp_card_word),
      .rsp_card_end     (rsp_card_end),
      .rsp_deck_end     (rsp_deck_end),
      .rsp_size_error   (rsp_size_error),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int draw_gap(bit quiet);
      if (quiet || no_gaps) return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic void queue_word(logic [63:0] w, logic ce, logic de, logic se);
      card_queue.push_back('{w, ce, de, se});
   endfunction

   function automatic void clear_deck();
      deck_offset   = '0;
      pending_bytes = '0;
      pending_count = '0;
      words_in_card = '0;
      overflow_seen = 1'b0;
   endfunction

   function automatic void frame_item(logic [7:0] b, logic valid, logic last);
      logic [63:0] full_word;
      logic [63:0] tail_word;
      if (valid && !overflow_seen) begin
         if (deck_offset >= DECK_LIMIT) begin
            overflow_seen = 1'b1;
            queue_word('0, 1'b0, 1'b1, 1'b1);
         end else begin
            if (pending_count == 0 && words_in_card == 0) begin
               queue_word({TXT_TAG, 16'h0000, deck_offset}, 1'b0, 1'b0, 1'b0);
               queue_word(LEN_FIELD, 1'b0, 1'b0, 1'b0);
            end
            full_word   = {pending_bytes, b};
            deck_offset = deck_offset + 16'd1;
            if (pending_count == 3'd7) begin
               queue_word(full_word, 1'b0, 1'b0, 1'b0);
               pending_bytes = '0;
               pending_count = '0;
               words_in_card = words_in_card + 3'd1;
               if (words_in_card >= PAYLOAD_WORDS) begin
                  queue_word('0, 1'b1, 1'b0, 1'b0);
                  words_in_card = '0;
               end
            end else begin
               pending_bytes = full_word[55:0];
               pending_count = pending_count + 3'd1;
            end
         end
      end
      if (last) begin
         if (!overflow_seen) begin
            if (pending_count != 0 || words_in_card != 0) begin
               if (pending_count != 0) begin
                  tail_word = {8'h00, pending_bytes} << (8 * (8 - pending_count));
                  queue_word(tail_word, 1'b0, 1'b0, 1'b0);
                  words_in_card = words_in_card + 3'd1;
               end
               while (words_in_card < PAYLOAD_WORDS) begin
                  queue_word('0, 1'b0, 1'b0, 1'b0);
                  words_in_card = words_in_card + 3'd1;
               end
               queue_word('0, 1'b1, 1'b0, 1'b0);
            end
            queue_word({END_TAG, 8'h00, entry_addr}, 1'b0, 1'b0, 1'b0);
            for (int k = 0; k < END_FILL_WORDS; k++)
               queue_word('0, 1'b0, 1'b0, 1'b0);
            queue_word('0, 1'b1, 1'b1, 1'b0);
         end
         clear_deck();
      end
   endfunction

   task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
   endtask

   task automatic check_result;
      card_result_type want;
      words_out++;
      if (card_queue.size() == 0) begin
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("%0t: unexpected result, expected none actual word %h ce %b de %b se %b",
                     $time, rsp_card_word, rsp_card_end, rsp_deck_end, rsp_size_error);
      end else begin
         want = card_queue.pop_front();
         if (want.word !== rsp_card_word)
            report_field("card_word", want.word, rsp_card_word);
         if (want.card_end !== rsp_card_end)
            report_field("card_end", want.card_end, rsp_card_end);
         if (want.deck_end !== rsp_deck_end)
            report_field("deck_end", want.deck_end, rsp_deck_end);
         if (want.size_error !== rsp_size_error)
            report_field("size_error", want.size_error, rsp_size_error);
         if (want.card_end) cards_out++;
         if (want.deck_end && !want.size_error) decks_out++;
         if (want.size_error) errors_out++;
      end
   endtask

   // monitor: register writes, accepted items, accepted results
   always @(posedge clock) begin
      if (reset) begin
         entry_addr = '0;
         clear_deck();
      end else begin
         if (csr_wr_en) entry_addr = csr_wr_data;
         if (req_push && !req_full) begin
            frame_item(req_data_byte, req_byte_valid, req_end_of_input);
            items_in++;
         end
         if (rsp_pop && !rsp_empty) check_result;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_wr_en)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, %0d results still expected", $time, card_queue.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side
   initial begin : rsp_side
      int gap;
      int hold;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold         = hold_request;
            hold_request = 0;
            rsp_pop <= 1'b0;
            repeat (hold) @(posedge clock);
            rsp_pop <= 1'b1;
         end else if (rsp_pop && !rsp_empty) begin
            if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
            gap = draw_gap(rx_quiet);
            if (gap > 0) begin
               rsp_pop <= 1'b0;
               repeat (gap) @(posedge clock);
               rsp_pop <= 1'b1;
            end
         end else begin
            rsp_pop <= !reset;
         end
      end
   end

   // req_push is left high after acceptance so back-to-back items need no toggle
   task automatic send_item(logic [7:0] b, logic valid, logic last);
      int gap;
      gap = draw_gap(tx_quiet);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push         <= 1'b1;
      req_data_byte    <= b;
      req_byte_valid   <= valid;
      req_end_of_input <= last;
      do @(posedge clock); while (req_full);
   endtask

   task automatic wait_idle;
      req_push <= 1'b0;
      @(posedge clock);
      while (card_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_entry(logic [23:0] value);
      wait_idle;
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      entry_writes++;
   endtask

   task automatic test_empty_deck;
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'hA5, 1'b0, 1'b1);
   endtask

   task automatic test_entry_extremes;
      write_entry(24'hFFFFFF);
      send_item(8'h00, 1'b0, 1'b1);
      write_entry(24'h000000);
      send_item(8'hFF, 1'b0, 1'b1);
      write_entry(24'($urandom_range(1, 24'hFFFFFE)));
      send_item(8'h5A, 1'b0, 1'b1);
   endtask

   task automatic test_single_bytes;
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      for (int i = 0; i < 8; i++)
         send_item(8'h80 >> i | 8'h01 << i, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
   endtask

   task automatic test_backpressure;
      wait_idle;
      hold_request = HOLD_CYCLES;
      tx_quiet     = 1'b1;
      for (int i = 0; i < 64; i++)
         send_item(8'($urandom), 1'b1, 1'b0);
      send_item(8'($urandom), 1'b0, 1'b1);
      tx_quiet = 1'b0;
   endtask

   task automatic test_size_limit;
      wait_idle;
      no_gaps = 1'b1;
      for (int i = 0; i < DECK_LIMIT; i++)
         send_item(8'($urandom), 1'b1, 1'b0);
      for (int i = 0; i < 4; i++)
         send_item(8'($urandom), 1'b1, 1'b0);
      send_item(8'($urandom), 1'b1, 1'b1);
      send_item(8'($urandom), 1'b0, 1'b1);
      no_gaps = 1'b0;
   endtask

   task automatic test_random_decks;
      int sent;
      int len;
      int pick;
      bit end_on_byte;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick == 0)      len = 0;
         else if (pick == 1) len = 56 * $urandom_range(1, 2);
         else if (pick == 2) len = 8 * $urandom_range(1, 8);
         else                len = $urandom_range(1, 70);
         end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
         if ($urandom_range(0, 3) == 0) begin
            pick = $urandom_range(0, 2);
            if (pick == 0)      write_entry(24'h000000);
            else if (pick == 1) write_entry(24'hFFFFFF);
            else                write_entry(24'($urandom));
         end
         tx_quiet = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 15) == 0)
               send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, end_on_byte && (k == len - 1));
            sent++;
         end
         if (!end_on_byte) begin
            send_item(8'($urandom), 1'b0, 1'b1);
            sent++;
         end
      end
      tx_quiet = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_deck;
      test_entry_extremes;
      test_single_bytes;
      test_backpressure;
      test_size_limit;
      test_random_decks;
      wait_idle;
      $display("run: %0d items in, %0d words out, %0d cards, %0d decks closed",
               items_in, words_out, cards_out, decks_out);
      $display("     %0d size errors, %0d entry address writes, input stalled under hold",
               errors_out, entry_writes);
      if (mismatches == 0 && card_queue.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: sim.f
design/cdrf_pkg.sv
design/cdrf_front.sv
design/cdrf_cmdq.sv
design/cdrf_back.sv
design/card_deck_record_framer.sv
tb/tb.sv
